// File: design/ptri_pkg.sv
`timescale 1ns / 1ps

package ptri_pkg;

    localparam int COORD_BITS_DEF = 20;

    // Projection plane codes
    typedef enum logic [1:0] {
        PLANE_XY = 2'd0,
        PLANE_YZ = 2'd1,
        PLANE_ZX = 2'd2
    } plane_t;

    // Result codes
    typedef enum logic [1:0] {
        CLASS_OUTSIDE  = 2'd0,
        CLASS_BOUNDARY = 2'd1,
        CLASS_INSIDE   = 2'd2
    } loc_class_t;

    // Control that rides along with every item through the pipeline
    typedef struct packed {
        logic hit;      // query equals a vertex
        logic strict;   // strict rule selected
    } ctrl_t;

endpackage

// File: design/point_in_projected_triangle.sv
`timescale 1ns / 1ps

// Point-in-triangle classifier on a coordinate plane. One query per cycle
// unless out_ready stalls. Stages: coordinate selection and differences, six
// signed (2*COORD_BITS+2)-bit products, numerator and
// denominator sums, sign normalization, then the exact compares against the
// denominator. Each stage carries its own valid bit and holds under stall, so
// empty stages fill even while a result waits on out_ready; in_ready follows
// out_ready combinationally through the stages. location_class: 0 outside,
// 1 on a vertex, edge or degenerate triangle (strict rule), 2 strictly inside.
// Point fields are 3*COORD_BITS wide, x in the low bits.

module point_in_projected_triangle
    import ptri_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [3*COORD_BITS-1:0]   vertex_a,
    input  logic [3*COORD_BITS-1:0]   vertex_b,
    input  logic [3*COORD_BITS-1:0]   vertex_c,
    input  logic [3*COORD_BITS-1:0]   query_point,
    input  logic [1:0]                projection_plane,
    input  logic                      rule_variant,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [1:0]                location_class
);

    localparam int CB = COORD_BITS;
    localparam int PW = 2 * COORD_BITS + 2;
    localparam int W  = 2 * COORD_BITS + 4;

    logic                 p_valid, p_ready;
    ctrl_t                p_ctrl;
    logic signed [CB:0]   bv_cv, au_cu, cu_bu, av_cv, pu_cu, pv_cv, cv_av;

    logic                 m_valid, m_ready;
    ctrl_t                m_ctrl;
    logic signed [PW-1:0] prod_d1, prod_d2, prod_a1, prod_a2, prod_b1, prod_b2;

    logic                 s_valid, s_ready;
    ctrl_t                s_ctrl;
    logic signed [W-1:0]  den, num_a, num_b, num_c;

    ptri_proj #(
        .COORD_BITS (COORD_BITS)
    ) u_proj (
        .clk              (clk),
        .rst_n            (rst_n),
        .up_valid         (in_valid),
        .up_ready         (in_ready),
        .vertex_a         (vertex_a),
        .vertex_b         (vertex_b),
        .vertex_c         (vertex_c),
        .query_point      (query_point),
        .projection_plane (projection_plane),
        .rule_variant     (rule_variant),
        .down_valid       (p_valid),
        .down_ready       (p_ready),
        .ctrl             (p_ctrl),
        .bv_cv            (bv_cv),
        .au_cu            (au_cu),
        .cu_bu            (cu_bu),
        .av_cv            (av_cv),
        .pu_cu            (pu_cu),
        .pv_cv            (pv_cv),
        .cv_av            (cv_av)
    );

    ptri_mul #(
        .COORD_BITS (COORD_BITS)
    ) u_mul (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (p_valid),
        .up_ready   (p_ready),
        .up_ctrl    (p_ctrl),
        .bv_cv      (bv_cv),
        .au_cu      (au_cu),
        .cu_bu      (cu_bu),
        .av_cv      (av_cv),
        .pu_cu      (pu_cu),
        .pv_cv      (pv_cv),
        .cv_av      (cv_av),
        .down_valid (m_valid),
        .down_ready (m_ready),
        .down_ctrl  (m_ctrl),
        .prod_d1    (prod_d1),
        .prod_d2    (prod_d2),
        .prod_a1    (prod_a1),
        .prod_a2    (prod_a2),
        .prod_b1    (prod_b1),
        .prod_b2    (prod_b2)
    );

    ptri_sum #(
        .COORD_BITS (COORD_BITS)
    ) u_sum (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (m_valid),
        .up_ready   (m_ready),
        .up_ctrl    (m_ctrl),
        .prod_d1    (prod_d1),
        .prod_d2    (prod_d2),
        .prod_a1    (prod_a1),
        .prod_a2    (prod_a2),
        .prod_b1    (prod_b1),
        .prod_b2    (prod_b2),
        .down_valid (s_valid),
        .down_ready (s_ready),
        .down_ctrl  (s_ctrl),
        .den        (den),
        .num_a      (num_a),
        .num_b      (num_b),
        .num_c      (num_c)
    );

    ptri_class #(
        .COORD_BITS (COORD_BITS)
    ) u_class (
        .clk            (clk),
        .rst_n          (rst_n),
        .up_valid       (s_valid),
        .up_ready       (s_ready),
        .up_ctrl        (s_ctrl),
        .den            (den),
        .num_a          (num_a),
        .num_b          (num_b),
        .num_c          (num_c),
        .down_valid     (out_valid),
        .down_ready     (out_ready),
        .location_class (location_class)
    );

endmodule

// File: design/ptri_proj.sv
`timescale 1ns / 1ps

module ptri_proj
    import ptri_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             up_valid,
    output logic                             up_ready,
    input  logic [3*COORD_BITS-1:0]          vertex_a,
    input  logic [3*COORD_BITS-1:0]          vertex_b,
    input  logic [3*COORD_BITS-1:0]          vertex_c,
    input  logic [3*COORD_BITS-1:0]          query_point,
    input  logic [1:0]                       projection_plane,
    input  logic                             rule_variant,
    output logic                             down_valid,
    input  logic                             down_ready,
    output ctrl_t                            ctrl,
    output logic signed [COORD_BITS:0]       bv_cv,
    output logic signed [COORD_BITS:0]       au_cu,
    output logic signed [COORD_BITS:0]       cu_bu,
    output logic signed [COORD_BITS:0]       av_cv,
    output logic signed [COORD_BITS:0]       pu_cu,
    output logic signed [COORD_BITS:0]       pv_cv,
    output logic signed [COORD_BITS:0]       cv_av
);

    localparam int CB = COORD_BITS;
    localparam int DW = COORD_BITS + 1;

    logic [1:0] u_sel;
    logic [1:0] v_sel;

    logic signed [CB-1:0] au, av, bu, bv, cu, cv, pu, pv;

    logic                 valid_reg;
    ctrl_t                ctrl_reg;
    ctrl_t                ctrl_next;
    logic signed [CB:0]   bv_cv_reg, au_cu_reg, cu_bu_reg, av_cv_reg;
    logic signed [CB:0]   pu_cu_reg, pv_cv_reg, cv_av_reg;
    logic signed [CB:0]   bv_cv_next, au_cu_next, cu_bu_next, av_cv_next;
    logic signed [CB:0]   pu_cu_next, pv_cv_next, cv_av_next;

    // Pick the two coordinates that survive the projection
    always_comb
    begin
        case (projection_plane)
            PLANE_YZ:
            begin
                u_sel = 2'd1;
                v_sel = 2'd2;
            end
            PLANE_ZX:
            begin
                u_sel = 2'd2;
                v_sel = 2'd0;
            end
            default:
            begin
                u_sel = 2'd0;
                v_sel = 2'd1;
            end
        endcase
    end

    assign au = $signed(vertex_a[u_sel*CB +: CB]);
    assign av = $signed(vertex_a[v_sel*CB +: CB]);
    assign bu = $signed(vertex_b[u_sel*CB +: CB]);
    assign bv = $signed(vertex_b[v_sel*CB +: CB]);
    assign cu = $signed(vertex_c[u_sel*CB +: CB]);
    assign cv = $signed(vertex_c[v_sel*CB +: CB]);
    assign pu = $signed(query_point[u_sel*CB +: CB]);
    assign pv = $signed(query_point[v_sel*CB +: CB]);

    assign bv_cv_next = DW'(bv) - DW'(cv);
    assign au_cu_next = DW'(au) - DW'(cu);
    assign cu_bu_next = DW'(cu) - DW'(bu);
    assign av_cv_next = DW'(av) - DW'(cv);
    assign pu_cu_next = DW'(pu) - DW'(cu);
    assign pv_cv_next = DW'(pv) - DW'(cv);
    assign cv_av_next = DW'(cv) - DW'(av);

    assign ctrl_next.hit    = (query_point == vertex_a) || (query_point == vertex_b) ||
                              (query_point == vertex_c);
    assign ctrl_next.strict = rule_variant;

    assign up_ready = !valid_reg || down_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            ctrl_reg  <= ctrl_next;
            bv_cv_reg <= bv_cv_next;
            au_cu_reg <= au_cu_next;
            cu_bu_reg <= cu_bu_next;
            av_cv_reg <= av_cv_next;
            pu_cu_reg <= pu_cu_next;
            pv_cv_reg <= pv_cv_next;
            cv_av_reg <= cv_av_next;
        end
    end

    assign down_valid = valid_reg;
    assign ctrl       = ctrl_reg;
    assign bv_cv      = bv_cv_reg;
    assign au_cu      = au_cu_reg;
    assign cu_bu      = cu_bu_reg;
    assign av_cv      = av_cv_reg;
    assign pu_cu      = pu_cu_reg;
    assign pv_cv      = pv_cv_reg;
    assign cv_av      = cv_av_reg;

endmodule

// File: design/ptri_mul.sv
`timescale 1ns / 1ps

module ptri_mul
    import ptri_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             up_valid,
    output logic                             up_ready,
    input  ctrl_t                            up_ctrl,
    input  logic signed [COORD_BITS:0]       bv_cv,
    input  logic signed [COORD_BITS:0]       au_cu,
    input  logic signed [COORD_BITS:0]       cu_bu,
    input  logic signed [COORD_BITS:0]       av_cv,
    input  logic signed [COORD_BITS:0]       pu_cu,
    input  logic signed [COORD_BITS:0]       pv_cv,
    input  logic signed [COORD_BITS:0]       cv_av,
    output logic                             down_valid,
    input  logic                             down_ready,
    output ctrl_t                            down_ctrl,
    output logic signed [2*COORD_BITS+1:0]   prod_d1,
    output logic signed [2*COORD_BITS+1:0]   prod_d2,
    output logic signed [2*COORD_BITS+1:0]   prod_a1,
    output logic signed [2*COORD_BITS+1:0]   prod_a2,
    output logic signed [2*COORD_BITS+1:0]   prod_b1,
    output logic signed [2*COORD_BITS+1:0]   prod_b2
);

    localparam int PW = 2 * COORD_BITS + 2;

    logic                 valid_reg;
    ctrl_t                ctrl_reg;
    logic signed [PW-1:0] d1_reg, d2_reg, a1_reg, a2_reg, b1_reg, b2_reg;
    logic signed [PW-1:0] d1_next, d2_next, a1_next, a2_next, b1_next, b2_next;

    assign d1_next = PW'(bv_cv) * PW'(au_cu);
    assign d2_next = PW'(cu_bu) * PW'(av_cv);
    assign a1_next = PW'(bv_cv) * PW'(pu_cu);
    assign a2_next = PW'(cu_bu) * PW'(pv_cv);
    assign b1_next = PW'(cv_av) * PW'(pu_cu);
    assign b2_next = PW'(au_cu) * PW'(pv_cv);

    assign up_ready = !valid_reg || down_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            ctrl_reg <= up_ctrl;
            d1_reg   <= d1_next;
            d2_reg   <= d2_next;
            a1_reg   <= a1_next;
            a2_reg   <= a2_next;
            b1_reg   <= b1_next;
            b2_reg   <= b2_next;
        end
    end

    assign down_valid = valid_reg;
    assign down_ctrl  = ctrl_reg;
    assign prod_d1    = d1_reg;
    assign prod_d2    = d2_reg;
    assign prod_a1    = a1_reg;
    assign prod_a2    = a2_reg;
    assign prod_b1    = b1_reg;
    assign prod_b2    = b2_reg;

endmodule

// File: design/ptri_sum.sv
`timescale 1ns / 1ps

module ptri_sum
    import ptri_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             up_valid,
    output logic                             up_ready,
    input  ctrl_t                            up_ctrl,
    input  logic signed [2*COORD_BITS+1:0]   prod_d1,
    input  logic signed [2*COORD_BITS+1:0]   prod_d2,
    input  logic signed [2*COORD_BITS+1:0]   prod_a1,
    input  logic signed [2*COORD_BITS+1:0]   prod_a2,
    input  logic signed [2*COORD_BITS+1:0]   prod_b1,
    input  logic signed [2*COORD_BITS+1:0]   prod_b2,
    output logic                             down_valid,
    input  logic                             down_ready,
    output ctrl_t                            down_ctrl,
    output logic signed [2*COORD_BITS+3:0]   den,
    output logic signed [2*COORD_BITS+3:0]   num_a,
    output logic signed [2*COORD_BITS+3:0]   num_b,
    output logic signed [2*COORD_BITS+3:0]   num_c
);

    localparam int W = 2 * COORD_BITS + 4;

    // Stage A: form d, na, nb
    logic                s1_valid_reg;
    logic                s1_ready;
    ctrl_t               s1_ctrl_reg;
    logic signed [W-1:0] s1_d_reg, s1_a_reg, s1_b_reg;
    logic signed [W-1:0] s1_d_next, s1_a_next, s1_b_next;

    // Stage B: make d non-negative, form nc
    logic                s2_valid_reg;
    ctrl_t               s2_ctrl_reg;
    logic signed [W-1:0] s2_d_reg, s2_a_reg, s2_b_reg, s2_c_reg;
    logic signed [W-1:0] s2_d_next, s2_a_next, s2_b_next, s2_c_next;

    assign s1_d_next = W'(prod_d1) + W'(prod_d2);
    assign s1_a_next = W'(prod_a1) + W'(prod_a2);
    assign s1_b_next = W'(prod_b1) + W'(prod_b2);

    assign up_ready = !s1_valid_reg || s1_ready;
    assign s1_ready = !s2_valid_reg || down_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (up_ready)
                s1_valid_reg <= up_valid;
            if (s1_ready)
                s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            s1_ctrl_reg <= up_ctrl;
            s1_d_reg    <= s1_d_next;
            s1_a_reg    <= s1_a_next;
            s1_b_reg    <= s1_b_next;
        end
    end

    always_comb
    begin
        if (s1_d_reg < 0)
        begin
            s2_d_next = -s1_d_reg;
            s2_a_next = -s1_a_reg;
            s2_b_next = -s1_b_reg;
        end
        else
        begin
            s2_d_next = s1_d_reg;
            s2_a_next = s1_a_reg;
            s2_b_next = s1_b_reg;
        end
        s2_c_next = s2_d_next - s2_a_next - s2_b_next;
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && s1_valid_reg)
        begin
            s2_ctrl_reg <= s1_ctrl_reg;
            s2_d_reg    <= s2_d_next;
            s2_a_reg    <= s2_a_next;
            s2_b_reg    <= s2_b_next;
            s2_c_reg    <= s2_c_next;
        end
    end

    assign down_valid = s2_valid_reg;
    assign down_ctrl  = s2_ctrl_reg;
    assign den        = s2_d_reg;
    assign num_a      = s2_a_reg;
    assign num_b      = s2_b_reg;
    assign num_c      = s2_c_reg;

endmodule

// File: design/ptri_class.sv
`timescale 1ns / 1ps

module ptri_class
    import ptri_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             up_valid,
    output logic                             up_ready,
    input  ctrl_t                            up_ctrl,
    input  logic signed [2*COORD_BITS+3:0]   den,
    input  logic signed [2*COORD_BITS+3:0]   num_a,
    input  logic signed [2*COORD_BITS+3:0]   num_b,
    input  logic signed [2*COORD_BITS+3:0]   num_c,
    output logic                             down_valid,
    input  logic                             down_ready,
    output logic [1:0]                       location_class
);

    logic       valid_reg;
    loc_class_t class_reg;
    loc_class_t class_next;

    logic d_zero;
    logic a_out, b_out, c_out;
    logic a_zero, b_zero, c_zero;
    logic a_full, b_full, c_full;
    logic c_open;

    // Compare each weight against 0 and 1 with d as the unit
    assign d_zero = (den == 0);
    assign a_out  = (num_a < 0) || (num_a > den);
    assign b_out  = (num_b < 0) || (num_b > den);
    assign c_out  = (num_c < 0) || (num_c > den);
    assign a_zero = (num_a == 0);
    assign b_zero = (num_b == 0);
    assign c_zero = (num_c == 0);
    assign a_full = (num_a == den);
    assign b_full = (num_b == den);
    assign c_full = (num_c == den);
    assign c_open = (num_c > 0) && (num_c < den);

    always_comb
    begin
        if (up_ctrl.hit)
            class_next = CLASS_BOUNDARY;
        else if (d_zero)
            class_next = up_ctrl.strict ? CLASS_BOUNDARY : CLASS_OUTSIDE;
        else if (a_out || b_out)
            class_next = CLASS_OUTSIDE;
        else if (!up_ctrl.strict)
        begin
            // general rule: c is only checked through the equality tests first
            if (a_zero || a_full || b_zero || b_full || c_zero || c_full)
                class_next = CLASS_BOUNDARY;
            else if (c_open)
                class_next = CLASS_INSIDE;
            else
                class_next = CLASS_OUTSIDE;
        end
        else if (c_out)
            class_next = CLASS_OUTSIDE;
        else if (a_zero || b_zero || c_zero)
            class_next = CLASS_BOUNDARY;
        else
            class_next = CLASS_INSIDE;
    end

    assign up_ready = !valid_reg || down_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
            class_reg <= class_next;
    end

    assign down_valid     = valid_reg;
    assign location_class = class_reg;

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb
    import ptri_pkg::*;
();

    localparam int CB   = COORD_BITS_DEF;
    localparam int PW   = 3 * CB;
    localparam int CMAX = (1 << (CB - 1)) - 1;
    localparam int CMIN = -(1 << (CB - 1));

    class query_scoreboard;
        loc_class_t pending_class[$];
        int         errors;
        int         checked;

        function new();
            errors  = 0;
            checked = 0;
        endfunction

        function longint coord_at(logic [PW-1:0] pt, int idx);
            logic signed [CB-1:0] c;
            c = pt[idx*CB +: CB];
            return longint'(c);
        endfunction

        // Exact barycentric classification on the selected plane.
        function loc_class_t locate(logic [PW-1:0] a, logic [PW-1:0] b, logic [PW-1:0] c,
                                    logic [PW-1:0] q, logic [1:0] plane, logic strict_rule);
            int     iu;
            int     iv;
            longint au, av, bu, bv, cu, cv, qu, qv;
            longint den, wa, wb, wc;
            // whole-field compare: no spare bits sit above the three coordinates
            if (q == a || q == b || q == c)
                return CLASS_BOUNDARY;
            case (plane)
                PLANE_YZ:
                begin
                    iu = 1;
                    iv = 2;
                end
                PLANE_ZX:
                begin
                    iu = 2;
                    iv = 0;
                end
                default:
                begin
                    iu = 0;
                    iv = 1;
                end
            endcase
            au = coord_at(a, iu);
            av = coord_at(a, iv);
            bu = coord_at(b, iu);
            bv = coord_at(b, iv);
            cu = coord_at(c, iu);
            cv = coord_at(c, iv);
            qu = coord_at(q, iu);
            qv = coord_at(q, iv);
            den = (bv - cv) * (au - cu) + (cu - bu) * (av - cv);
            if (den == 0)
                return strict_rule ? CLASS_BOUNDARY : CLASS_OUTSIDE;
            wa = (bv - cv) * (qu - cu) + (cu - bu) * (qv - cv);
            wb = (cv - av) * (qu - cu) + (au - cu) * (qv - cv);
            if (den < 0)
            begin
                den = -den;
                wa  = -wa;
                wb  = -wb;
            end
            wc = den - wa - wb;
            if (wa < 0 || wa > den || wb < 0 || wb > den)
                return CLASS_OUTSIDE;
            if (!strict_rule)
            begin
                // general rule: weight c is not range checked before the edge tests
                if (wa == 0 || wa == den || wb == 0 || wb == den || wc == 0 || wc == den)
                    return CLASS_BOUNDARY;
                return (wc > 0 && wc < den) ? CLASS_INSIDE : CLASS_OUTSIDE;
            end
            if (wc < 0 || wc > den)
                return CLASS_OUTSIDE;
            if (wa == 0 || wb == 0 || wc == 0)
                return CLASS_BOUNDARY;
            return CLASS_INSIDE;
        endfunction

        function void note_query(logic [PW-1:0] a, logic [PW-1:0] b, logic [PW-1:0] c,
                                 logic [PW-1:0] q, logic [1:0] plane, logic strict_rule);
            pending_class.push_back(locate(a, b, c, q, plane, strict_rule));
        endfunction

        function void check_class(logic [1:0] got);
            loc_class_t want;
            if (pending_class.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: class %0d with nothing pending", got);
                return;
            end
            want = pending_class.pop_front();
            checked++;
            if (got !== want)
            begin
                errors++;
                if (errors <= 10)
                    $display("result %0d: expected class %0d, got %0d", checked, want, got);
            end
        endfunction
    endclass

    logic          clk;
    logic          rst_n            = 1'b0;
    logic          in_valid         = 1'b0;
    logic          in_ready;
    logic [PW-1:0] vertex_a         = '0;
    logic [PW-1:0] vertex_b         = '0;
    logic [PW-1:0] vertex_c         = '0;
    logic [PW-1:0] query_point      = '0;
    logic [1:0]    projection_plane = PLANE_XY;
    logic          rule_variant     = 1'b0;
    logic          out_valid;
    logic          out_ready        = 1'b0;
    logic [1:0]    location_class;

    int in_gap_pct    = 0;
    int out_stall_pct = 0;

    query_scoreboard sb = new();

    point_in_projected_triangle u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .vertex_a         (vertex_a),
        .vertex_b         (vertex_b),
        .vertex_c         (vertex_c),
        .query_point      (query_point),
        .projection_plane (projection_plane),
        .rule_variant     (rule_variant),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .location_class   (location_class)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= out_stall_pct);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_query(vertex_a, vertex_b, vertex_c, query_point,
                              projection_plane, rule_variant);
            if (out_valid && out_ready)
                sb.check_class(location_class);
        end
    end

    function automatic logic [PW-1:0] pack_point(int x, int y, int z);
        return {z[CB-1:0], y[CB-1:0], x[CB-1:0]};
    endfunction

    function automatic int rand_coord(int span);
        return int'($urandom_range(2 * span)) - span;
    endfunction

    function automatic logic [PW-1:0] noise_field();
        logic [63:0] w;
        w = {$urandom(), $urandom()};
        return w[PW-1:0];
    endfunction

    task automatic send_query(logic [PW-1:0] a, logic [PW-1:0] b, logic [PW-1:0] c,
                              logic [PW-1:0] q, logic [1:0] plane, logic strict_rule);
        int gap;
        gap = 0;
        while ($urandom_range(99) < in_gap_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid         <= 1'b1;
        vertex_a         <= a;
        vertex_b         <= b;
        vertex_c         <= c;
        query_point      <= q;
        projection_plane <= plane;
        rule_variant     <= strict_rule;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic send_random_query();
        int         pts[4][3];
        int         dir[3];
        int         ext[5];
        int         mode;
        int         span;
        int         k;
        int         j;
        int         m;
        int         off;
        logic [1:0] plane;
        logic       strict_rule;
        ext         = '{CMIN, CMAX, 0, -1, 1};
        plane       = ($urandom_range(15) == 0) ? 2'd3 : 2'($urandom_range(2));
        strict_rule = 1'($urandom_range(1));
        mode        = $urandom_range(9);
        span        = (mode == 7) ? CMAX : (mode <= 2) ? 8 : 2000;
        for (k = 0; k < 4; k++)
            for (j = 0; j < 3; j++)
                pts[k][j] = rand_coord(span);
        k   = $urandom_range(2);
        off = (k + 1) % 3;
        case (mode)
            3:
                for (j = 0; j < 3; j++)
                    pts[3][j] = (pts[0][j] + pts[1][j] + pts[2][j]) / 3;
            4:
                for (j = 0; j < 3; j++)
                    pts[3][j] = pts[k][j];
            5:
            begin
                // even coordinates keep the edge midpoint exact
                for (m = 0; m < 3; m++)
                    for (j = 0; j < 3; j++)
                        pts[m][j] = 2 * pts[m][j];
                for (j = 0; j < 3; j++)
                    pts[3][j] = (pts[k][j] + pts[off][j]) / 2;
            end
            6:
            begin
                for (j = 0; j < 3; j++)
                    dir[j] = rand_coord(50);
                for (m = 1; m < 3; m++)
                    for (j = 0; j < 3; j++)
                        pts[m][j] = pts[0][j] + int'($urandom_range(20)) * dir[j];
            end
            8:
            begin
                // land on a vertex in the plane but not in space
                for (j = 0; j < 3; j++)
                    pts[3][j] = pts[k][j];
                case (plane)
                    PLANE_YZ: off = 0;
                    PLANE_ZX: off = 1;
                    default:  off = 2;
                endcase
                pts[3][off] = rand_coord(span);
            end
            9:
                for (m = 0; m < 4; m++)
                    for (j = 0; j < 3; j++)
                        pts[m][j] = ext[$urandom_range(4)];
            default:
            begin
            end
        endcase
        if (mode == 0)
            send_query(noise_field(), noise_field(), noise_field(), noise_field(),
                       plane, strict_rule);
        else
            send_query(pack_point(pts[0][0], pts[0][1], pts[0][2]),
                       pack_point(pts[1][0], pts[1][1], pts[1][2]),
                       pack_point(pts[2][0], pts[2][1], pts[2][2]),
                       pack_point(pts[3][0], pts[3][1], pts[3][2]),
                       plane, strict_rule);
    endtask

    task automatic send_directed();
        logic [PW-1:0] a0;
        logic [PW-1:0] b10;
        logic [PW-1:0] c10;
        a0  = pack_point(0, 0, 0);
        b10 = pack_point(10, 0, 0);
        c10 = pack_point(0, 10, 0);
        // plain inside, both rules, both windings
        send_query(a0, b10, c10, pack_point(2, 2, 0), PLANE_XY, 1'b0);
        send_query(a0, b10, c10, pack_point(2, 2, 0), PLANE_XY, 1'b1);
        send_query(a0, c10, b10, pack_point(2, 2, 5), PLANE_XY, 1'b0);
        // on an edge
        send_query(a0, b10, c10, pack_point(5, 0, 0), PLANE_XY, 1'b0);
        send_query(a0, b10, c10, pack_point(5, 0, 0), PLANE_XY, 1'b1);
        // exact vertex hit, and a hit in the plane only
        send_query(a0, b10, c10, b10, PLANE_XY, 1'b0);
        send_query(a0, b10, c10, pack_point(0, 0, 7), PLANE_XY, 1'b1);
        // outside
        send_query(a0, b10, c10, pack_point(20, 20, 0), PLANE_XY, 1'b0);
        send_query(a0, b10, c10, pack_point(20, 20, 0), PLANE_XY, 1'b1);
        // collinear triangle: rules disagree
        send_query(a0, pack_point(5, 5, 0), pack_point(10, 10, 0), pack_point(3, 1, 0),
                   PLANE_XY, 1'b0);
        send_query(a0, pack_point(5, 5, 0), pack_point(10, 10, 0), pack_point(3, 1, 0),
                   PLANE_XY, 1'b1);
        // weight a equals one while weight c is negative
        send_query(a0, b10, c10, pack_point(5, -5, 0), PLANE_XY, 1'b0);
        send_query(a0, b10, c10, pack_point(5, -5, 0), PLANE_XY, 1'b1);
        send_query(a0, b10, c10, pack_point(3, -1, 0), PLANE_XY, 1'b0);
        // other planes, and the unused plane code
        send_query(pack_point(9, 0, 0), pack_point(-3, 10, 0), pack_point(4, 0, 10),
                   pack_point(100, 2, 2), PLANE_YZ, 1'b0);
        send_query(pack_point(0, 5, 0), pack_point(0, -8, 10), pack_point(10, 3, 0),
                   pack_point(2, 77, 2), PLANE_ZX, 1'b1);
        send_query(a0, b10, c10, pack_point(2, 2, 0), 2'd3, 1'b1);
        // coordinate extremes
        send_query(pack_point(CMIN, CMIN, CMIN), pack_point(CMAX, CMIN, 0),
                   pack_point(CMIN, CMAX, 0), pack_point(0, 0, CMAX), PLANE_XY, 1'b1);
        send_query(pack_point(CMIN, CMIN, CMIN), pack_point(CMIN, CMAX, 0),
                   pack_point(CMAX, CMIN, 0), pack_point(0, 0, CMAX), PLANE_XY, 1'b0);
        send_query(pack_point(CMIN, CMIN, CMIN), pack_point(CMAX, CMIN, 0),
                   pack_point(CMIN, CMAX, 0), pack_point(CMAX, CMAX, CMAX), PLANE_ZX, 1'b0);
        send_query('0, {PW{1'b1}}, pack_point(CMAX, CMIN, CMAX), {PW{1'b1}},
                   PLANE_YZ, 1'b0);
        send_query({PW{1'b1}}, pack_point(CMAX, CMAX, CMAX), pack_point(CMIN, 0, CMAX),
                   '0, PLANE_ZX, 1'b1);
        // all vertices coincide
        send_query(b10, b10, b10, b10, PLANE_XY, 1'b1);
        send_query(b10, b10, b10, c10, PLANE_XY, 1'b0);
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        in_gap_pct    = 10;
        out_stall_pct = 50;
        send_directed();
        repeat (143) send_random_query();

        in_gap_pct    = 50;
        out_stall_pct = 10;
        repeat (143) send_random_query();

        in_gap_pct    = 0;
        out_stall_pct = 0;
        repeat (144) send_random_query();
        in_valid <= 1'b0;

        while (sb.pending_class.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (sb.pending_class.size() != 0)
            $display("%0d results never arrived", sb.pending_class.size());
        if (sb.errors == 0 && sb.pending_class.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("timeout waiting for the pipeline to drain");
        $display("Test completed with failures");
        $finish;
    end

endmodule
